[hdl/cosine_similarity_engine_macros.svh]
// assertion helpers used by the checker file
`ifndef COSINE_SIMILARITY_ENGINE_MACROS_SVH
`define COSINE_SIMILARITY_ENGINE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CSE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define CSE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/cse_pkg.sv]
// ----------------------------------------------------------------------------
// cse_pkg
// Widths, limits and shared types of the cosine similarity engine.
// ----------------------------------------------------------------------------
package cse_pkg;

    localparam int ELEM_W     = 16;
    localparam int SIM_W      = 16;
    localparam int ACC_W      = 48;
    localparam int ROOT_W     = 32;
    localparam int DIV_W      = 64;
    localparam int MUL_W      = ROOT_W + 1;
    localparam int CSUB_W     = 66;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 80;
    localparam int CNT_W      = 7;
    localparam int Q_W        = 18;
    localparam int SQ_REM_W   = 34;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // magnitude limits of the q1.15 result
    localparam logic [Q_W-1:0] LIM_POS = Q_W'(32767);
    localparam logic [Q_W-1:0] LIM_NEG = Q_W'(32768);

    typedef struct packed {
        logic              ge;
        logic [CSUB_W-1:0] diff;
    } t_csub_res;

endpackage

[hdl/cse_if.sv]
// ----------------------------------------------------------------------------
// cse_in_if / cse_out_if
// Valid/ready channels carrying element pairs in and similarity items out.
// ----------------------------------------------------------------------------
interface cse_in_if;
    import cse_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] elem_a;
    logic signed [ELEM_W-1:0] elem_b;
    logic                     last;

    modport source (output valid, elem_a, elem_b, last, input ready);
    modport sink   (input valid, elem_a, elem_b, last, output ready);
endinterface

interface cse_out_if;
    import cse_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SIM_W-1:0] similarity;
    logic                    zero_norm;

    modport source (output valid, similarity, zero_norm, input ready);
    modport sink   (input valid, similarity, zero_norm, output ready);
endinterface

[hdl/cse_csub.sv]
// ----------------------------------------------------------------------------
// cse_csub
// Shared compare-subtract unit used by the square root and divide steps.
// ----------------------------------------------------------------------------
module cse_csub (
    input  logic [cse_pkg::CSUB_W-1:0] i_opa,
    input  logic [cse_pkg::CSUB_W-1:0] i_opb,
    output cse_pkg::t_csub_res         o_res
);
    import cse_pkg::*;

    logic [CSUB_W:0] w_full;

    assign w_full     = {1'b0, i_opa} - {1'b0, i_opb};
    assign o_res.ge   = ~w_full[CSUB_W];
    assign o_res.diff = w_full[CSUB_W-1:0];

endmodule

[hdl/cosine_similarity_engine.sv]
// ----------------------------------------------------------------------------
// cosine_similarity_engine
// Streaming cosine similarity of two q3.12 vectors, result in q1.15.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one element pair (elem_a, elem_b) per item, last marks the
//   final pair of a vector. o_out carries one item per vector: similarity
//   (q1.15, +1.0 saturates to 32767) and zero_norm (either norm was zero,
//   similarity then 0).
//   Every pair is accepted in S_IDLE and then passes S_MUL_AB, S_ACC_AB,
//   S_ACC_AA and S_ACC_BB, in which one 33x33 multiplier is used three
//   times (a*b, a*a, b*b), each product added into its saturating 48-bit sum.
//   A last pair then goes through one shared compare-subtract unit:
//   32 steps for each square root, one multiply for the norm product and
//   80 steps of restoring division; the engine returns to idle for the
//   next pair at the same edge at which the result is written.
//   A zero norm skips the root and divide, going from S_CHECK to S_EMIT.
//   i_in.ready is high only while the engine is idle.
//   A result sits in the output register until taken; a receiver stall
//   holds the engine before it writes the next result, never drops it.
//   Reset clears the sums, the sequencer and the output valid.
// ----------------------------------------------------------------------------
module cosine_similarity_engine (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cse_in_if.sink    i_in,
    cse_out_if.source o_out
);
    import cse_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_MUL_AB = 12'b0000_0000_0010,
        S_ACC_AB = 12'b0000_0000_0100,
        S_ACC_AA = 12'b0000_0000_1000,
        S_ACC_BB = 12'b0000_0001_0000,
        S_CHECK  = 12'b0000_0010_0000,
        S_SQRT_A = 12'b0000_0100_0000,
        S_SQRT_B = 12'b0000_1000_0000,
        S_MUL_D  = 12'b0001_0000_0000,
        S_DIV    = 12'b0010_0000_0000,
        S_EMIT   = 12'b0100_0000_0000,
        S_SPARE  = 12'b1000_0000_0000
    } t_state;

    // control registers
    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_out_valid, n_out_valid;
    logic signed [ACC_W-1:0] r_dot, n_dot;
    logic signed [ACC_W-1:0] r_na_sum, n_na_sum;
    logic signed [ACC_W-1:0] r_nb_sum, n_nb_sum;

    // datapath registers
    logic signed [ELEM_W-1:0] r_a, n_a;
    logic signed [ELEM_W-1:0] r_b, n_b;
    logic                     r_last, n_last;
    logic [DIV_W-1:0]         r_prod, n_prod;
    logic [DIV_W-1:0]         r_x, n_x;
    logic [DIV_W-1:0]         r_rem, n_rem;
    logic [ROOT_W-1:0]        r_root, n_root;
    logic [ROOT_W-1:0]        r_na, n_na;
    logic [Q_W-1:0]           r_q, n_q;
    logic                     r_ovf, n_ovf;
    logic                     r_neg, n_neg;
    logic                     r_zero, n_zero;
    logic signed [SIM_W-1:0]  r_sim, n_sim;
    logic                     r_zero_out, n_zero_out;

    // shared multiplier
    logic signed [MUL_W-1:0]   w_mul_a, w_mul_b;
    logic signed [2*MUL_W-1:0] w_mul_p;

    // saturating accumulate
    logic signed [ACC_W-1:0] w_acc_sel;
    logic signed [ACC_W:0]   w_sum;
    logic signed [ACC_W-1:0] w_sum_sat;

    // shared compare-subtract
    logic [CSUB_W-1:0]   w_opa, w_opb;
    t_csub_res           w_cs;
    logic [SQ_REM_W+1:0] w_sh_sq;
    logic [DIV_W:0]      w_sh_dv;

    // result rounding
    logic [Q_W:0]            w_q1;
    logic [Q_W-1:0]          w_m;
    logic [Q_W-1:0]          w_lim;
    logic [Q_W-1:0]          w_m_sat;
    logic [ACC_W-1:0]        w_mag;
    logic                    w_last_step;
    logic                    w_out_free;

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.similarity = r_sim;
    assign o_out.zero_norm  = r_zero_out;
    assign w_out_free       = ~r_out_valid | o_out.ready;

    always_comb begin
        case (r_state)
            S_MUL_AB: begin
                w_mul_a = MUL_W'(r_a);
                w_mul_b = MUL_W'(r_b);
            end
            S_ACC_AB: begin
                w_mul_a = MUL_W'(r_a);
                w_mul_b = MUL_W'(r_a);
            end
            S_ACC_AA: begin
                w_mul_a = MUL_W'(r_b);
                w_mul_b = MUL_W'(r_b);
            end
            S_MUL_D: begin
                w_mul_a = $signed({1'b0, r_na});
                w_mul_b = $signed({1'b0, r_root});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    always_comb begin
        case (r_state)
            S_ACC_AB: w_acc_sel = r_dot;
            S_ACC_AA: w_acc_sel = r_na_sum;
            S_ACC_BB: w_acc_sel = r_nb_sum;
            default:  w_acc_sel = '0;
        endcase
    end

    assign w_sum = {w_acc_sel[ACC_W-1], w_acc_sel} + {r_prod[ACC_W-1], r_prod[ACC_W-1:0]};

    always_comb begin
        if (w_sum[ACC_W] != w_sum[ACC_W-1]) begin
            w_sum_sat = w_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            w_sum_sat = w_sum[ACC_W-1:0];
        end
    end

    // root step brings down two radicand bits, divide step one dividend bit
    assign w_sh_sq = {r_rem[SQ_REM_W-1:0], r_x[DIV_W-1 -: 2]};
    assign w_sh_dv = {r_rem, r_x[DIV_W-1]};

    always_comb begin
        if (r_state == S_DIV) begin
            w_opa = {1'b0, w_sh_dv};
            w_opb = {2'b00, r_prod};
        end else begin
            w_opa = CSUB_W'(w_sh_sq);
            w_opb = CSUB_W'({r_root, 2'b01});
        end
    end

    cse_csub u_csub (
        .i_opa (w_opa),
        .i_opb (w_opb),
        .o_res (w_cs)
    );

    assign w_last_step = (r_state == S_DIV) ? (r_cnt == CNT_W'(DIV_STEPS - 1))
                                            : (r_cnt == CNT_W'(SQRT_STEPS - 1));

    assign w_mag = r_dot[ACC_W-1] ? (ACC_W'(0) - ACC_W'(r_dot)) : ACC_W'(r_dot);

    // round half up on the one extra quotient bit, then clamp
    assign w_q1    = {1'b0, r_q} + (Q_W+1)'(1);
    assign w_m     = w_q1[Q_W:1];
    assign w_lim   = r_neg ? LIM_NEG : LIM_POS;
    assign w_m_sat = (r_ovf || (w_m > w_lim)) ? w_lim : w_m;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_dot       = r_dot;
        n_na_sum    = r_na_sum;
        n_nb_sum    = r_nb_sum;
        n_a         = r_a;
        n_b         = r_b;
        n_last      = r_last;
        n_prod      = r_prod;
        n_x         = r_x;
        n_rem       = r_rem;
        n_root      = r_root;
        n_na        = r_na;
        n_q         = r_q;
        n_ovf       = r_ovf;
        n_neg       = r_neg;
        n_zero      = r_zero;
        n_sim       = r_sim;
        n_zero_out  = r_zero_out;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_a     = i_in.elem_a;
                    n_b     = i_in.elem_b;
                    n_last  = i_in.last;
                    n_state = S_MUL_AB;
                end
            end
            S_MUL_AB: begin
                n_prod  = w_mul_p[DIV_W-1:0];
                n_state = S_ACC_AB;
            end
            S_ACC_AB: begin
                n_dot   = w_sum_sat;
                n_prod  = w_mul_p[DIV_W-1:0];
                n_state = S_ACC_AA;
            end
            S_ACC_AA: begin
                n_na_sum = w_sum_sat;
                n_prod   = w_mul_p[DIV_W-1:0];
                n_state  = S_ACC_BB;
            end
            S_ACC_BB: begin
                n_nb_sum = w_sum_sat;
                n_state  = r_last ? S_CHECK : S_IDLE;
            end
            S_CHECK: begin
                n_zero = (r_na_sum == '0) || (r_nb_sum == '0);
                n_x    = {r_na_sum, 16'h0000};
                n_rem  = '0;
                n_root = '0;
                n_cnt  = '0;
                n_state = n_zero ? S_EMIT : S_SQRT_A;
            end
            S_SQRT_A, S_SQRT_B: begin
                n_x    = {r_x[DIV_W-3:0], 2'b00};
                n_rem  = DIV_W'(w_cs.ge ? w_cs.diff[SQ_REM_W-1:0] : w_sh_sq[SQ_REM_W-1:0]);
                n_root = {r_root[ROOT_W-2:0], w_cs.ge};
                n_cnt  = r_cnt + CNT_W'(1);
                if (w_last_step) begin
                    n_cnt = '0;
                    if (r_state == S_SQRT_A) begin
                        n_na    = n_root;
                        n_root  = '0;
                        n_rem   = '0;
                        n_x     = {r_nb_sum, 16'h0000};
                        n_state = S_SQRT_B;
                    end else begin
                        n_state = S_MUL_D;
                    end
                end
            end
            S_MUL_D: begin
                n_prod  = w_mul_p[DIV_W-1:0];
                n_neg   = r_dot[ACC_W-1];
                n_x     = {w_mag, 16'h0000};
                n_rem   = '0;
                n_q     = '0;
                n_ovf   = 1'b0;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_x   = {r_x[DIV_W-2:0], 1'b0};
                n_rem = w_cs.ge ? w_cs.diff[DIV_W-1:0] : w_sh_dv[DIV_W-1:0];
                n_q   = {r_q[Q_W-2:0], w_cs.ge};
                n_ovf = r_ovf | r_q[Q_W-1];
                n_cnt = r_cnt + CNT_W'(1);
                if (w_last_step) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_zero_out  = r_zero;
                    if (r_zero) begin
                        n_sim = '0;
                    end else if (r_neg) begin
                        n_sim = SIM_W'(16'h0000 - w_m_sat[SIM_W-1:0]);
                    end else begin
                        n_sim = w_m_sat[SIM_W-1:0];
                    end
                    n_dot    = '0;
                    n_na_sum = '0;
                    n_nb_sum = '0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_dot       <= '0;
            r_na_sum    <= '0;
            r_nb_sum    <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_dot       <= n_dot;
            r_na_sum    <= n_na_sum;
            r_nb_sum    <= n_nb_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a        <= n_a;
        r_b        <= n_b;
        r_last     <= n_last;
        r_prod     <= n_prod;
        r_x        <= n_x;
        r_rem      <= n_rem;
        r_root     <= n_root;
        r_na       <= n_na;
        r_q        <= n_q;
        r_ovf      <= n_ovf;
        r_neg      <= n_neg;
        r_zero     <= n_zero;
        r_sim      <= n_sim;
        r_zero_out <= n_zero_out;
    end

endmodule

[hdl/cse_checker.sv]
// ----------------------------------------------------------------------------
// cse_port_props
// Port-level checks of the cosine similarity engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "cosine_similarity_engine_macros.svh"

module cse_port_props (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic signed [cse_pkg::SIM_W-1:0] i_similarity,
    input logic                           i_zero_norm
);
    import cse_pkg::*;

    // a stalled result item holds
    `CSE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_similarity) && $stable(i_zero_norm), "stalled result changed")

    // a zero norm always reports zero similarity
    `CSE_ASSERT_IMP(a_zero_sim, i_clk, i_rst_n, i_out_valid && i_zero_norm, i_similarity == '0, "zero norm with non-zero similarity")

    // an accepted item keeps the engine busy for at least the next cycle
    `CSE_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "ready straight after accept")

    // a result only appears out of a busy cycle
    `CSE_ASSERT_IMP(a_result_from_busy, i_clk, i_rst_n, $rose(i_out_valid), !$past(i_in_ready), "result raised while idle")

endmodule

bind cosine_similarity_engine cse_port_props u_cse_port_props (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_similarity (o_out.similarity),
    .i_zero_norm  (o_out.zero_norm)
);
